/* hw/rtl/ssr_pkg.sv */
package ssr_pkg;

  // Fixed field widths
  localparam int ByteW    = 8;
  localparam int CfgDataW = 64;
  localparam int CfgIdxW  = 2;
  localparam int LenW     = 4;

  // Default sizes; the 64-bit byte registers hold at most eight characters
  localparam int MaxPatternDef = 8;
  localparam int MaxReplDef    = 8;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_PATTERN_BYTES = 2'd0,
    REG_PATTERN_LEN   = 2'd1,
    REG_REPL_BYTES    = 2'd2,
    REG_REPL_LEN      = 2'd3
  } cfg_reg_e;

  // Kind of burst held in the output buffer
  typedef struct packed {
    logic eot;     // burst closes the string, last goes on its final byte
    logic marker;  // empty end marker, no text byte
  } burst_info_t;

endpackage

/* hw/rtl/ssr_step.sv */
module ssr_step import ssr_pkg::*; #(
  parameter int MAX_PATTERN     = MaxPatternDef,
  parameter int MAX_REPLACEMENT = MaxReplDef,
  localparam int BufDepth = (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN : MAX_REPLACEMENT,
  localparam int PCntW    = $clog2(MAX_PATTERN + 1),
  localparam int RCntW    = $clog2(MAX_REPLACEMENT + 1),
  localparam int BCntW    = $clog2(BufDepth + 1)
) (
  input  logic [ByteW-1:0]    win_i [MAX_PATTERN],
  input  logic [PCntW-1:0]    wcnt_i,
  input  logic [ByteW-1:0]    char_i,
  input  logic                eot_i,
  input  logic [CfgDataW-1:0] pattern_i,
  input  logic [PCntW-1:0]    plen_i,
  input  logic [CfgDataW-1:0] repl_i,
  input  logic [RCntW-1:0]    rlen_i,
  output logic [ByteW-1:0]    win_o [MAX_PATTERN],
  output logic [PCntW-1:0]    wcnt_o,
  output logic [ByteW-1:0]    burst_o [BufDepth],
  output logic [BCntW-1:0]    burst_len_o,
  output burst_info_t         burst_info_o
);

  logic [ByteW-1:0] ins_win [MAX_PATTERN];
  logic [PCntW-1:0] ins_cnt;
  logic             decide;
  logic             match;
  logic [PCntW-1:0] drop;

  // Append the new byte behind the held ones
  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      ins_win[i] = win_i[i];
      if (wcnt_i == PCntW'(i)) begin
        ins_win[i] = char_i;
      end
    end
    ins_cnt = (wcnt_i < PCntW'(MAX_PATTERN)) ? wcnt_i + PCntW'(1) : wcnt_i;
  end

  // Compare the oldest plen bytes against the pattern
  always_comb begin
    decide = (ins_cnt >= plen_i);
    match  = 1'b1;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if (PCntW'(i) < plen_i && ins_win[i] != pattern_i[ByteW*i +: ByteW]) begin
        match = 1'b0;
      end
    end
    if (!decide) begin
      drop = '0;
    end else if (match) begin
      drop = plen_i;
    end else begin
      drop = PCntW'(1);
    end
  end

  // Next window: drop consumed bytes from the front, or clear at end of text
  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      win_o[i] = '0;
      if (!eot_i) begin
        for (int k = 0; k <= MAX_PATTERN; k++) begin
          if (i + k < MAX_PATTERN) begin
            if (drop == PCntW'(k) && PCntW'(i + k) < ins_cnt) begin
              win_o[i] = ins_win[i + k];
            end
          end
        end
      end
    end
    wcnt_o = eot_i ? '0 : ins_cnt - drop;
  end

  // Results of this item
  always_comb begin
    for (int i = 0; i < BufDepth; i++) begin
      burst_o[i] = '0;
    end
    burst_len_o  = '0;
    burst_info_o = '0;
    if (eot_i) begin
      burst_info_o.eot = 1'b1;
      for (int i = 0; i < MAX_PATTERN; i++) begin
        burst_o[i] = win_i[i];
      end
      if (wcnt_i == '0) begin
        burst_info_o.marker = 1'b1;
        burst_o[0]          = '0;
        burst_len_o         = BCntW'(1);
      end else begin
        burst_len_o = BCntW'(wcnt_i);
      end
    end else if (decide && match) begin
      for (int i = 0; i < MAX_REPLACEMENT; i++) begin
        burst_o[i] = repl_i[ByteW*i +: ByteW];
      end
      burst_len_o = BCntW'(rlen_i);
    end else if (decide) begin
      burst_o[0]  = ins_win[0];
      burst_len_o = BCntW'(1);
    end
  end

endmodule

/* hw/rtl/stream_substring_replace.sv */
// Streaming find-and-replace. Text bytes enter on the input channel; every
// non-overlapping occurrence of the configured pattern (1 to MAX_PATTERN
// bytes) is replaced, greedily from left to right, by the replacement (0 to
// MAX_REPLACEMENT bytes). An end_of_text item flushes the held bytes and
// flags the final one with last; with nothing held it yields one empty
// marker (char_valid low, last high). Each accepted item is evaluated
// combinationally from a one-entry input register and loads a shift
// buffer that delivers one result per cycle while the output is not
// stalled; plain text flows at one byte per cycle on the same condition.
// An item with n > 1 results (a replacement or a flush) holds the output
// buffer until all n are sent. The input register takes one more item
// while the buffer drains. Write configuration only while the block is idle.
module stream_substring_replace import ssr_pkg::*; #(
  parameter int MAX_PATTERN     = MaxPatternDef,
  parameter int MAX_REPLACEMENT = MaxReplDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  // input channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [ByteW-1:0]    char_in_i,
  input  logic                end_of_text_i,
  // output channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [ByteW-1:0]    char_out_o,
  output logic                char_valid_o,
  output logic                last_o
);

  localparam int BufDepth = (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN : MAX_REPLACEMENT;
  localparam int PCntW    = $clog2(MAX_PATTERN + 1);
  localparam int RCntW    = $clog2(MAX_REPLACEMENT + 1);
  localparam int BCntW    = $clog2(BufDepth + 1);

  // Configuration registers
  logic [CfgDataW-1:0] pat_bytes_q;
  logic [LenW-1:0]     pat_len_q;
  logic [CfgDataW-1:0] repl_bytes_q;
  logic [LenW-1:0]     repl_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_bytes_q  <= '0;
      pat_len_q    <= LenW'(1);
      repl_bytes_q <= '0;
      repl_len_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_PATTERN_BYTES: pat_bytes_q  <= cfg_wdata_i;
        REG_PATTERN_LEN:   pat_len_q    <= cfg_wdata_i[LenW-1:0];
        REG_REPL_BYTES:    repl_bytes_q <= cfg_wdata_i;
        REG_REPL_LEN:      repl_len_q   <= cfg_wdata_i[LenW-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the length registers to the supported range
  logic [PCntW-1:0] plen_eff;
  logic [RCntW-1:0] rlen_eff;

  always_comb begin
    if (pat_len_q == '0) begin
      plen_eff = PCntW'(1);
    end else if (pat_len_q > LenW'(MAX_PATTERN)) begin
      plen_eff = PCntW'(MAX_PATTERN);
    end else begin
      plen_eff = PCntW'(pat_len_q);
    end
    if (repl_len_q > LenW'(MAX_REPLACEMENT)) begin
      rlen_eff = RCntW'(MAX_REPLACEMENT);
    end else begin
      rlen_eff = RCntW'(repl_len_q);
    end
  end

  // Handshake control
  logic             inq_valid_q;
  logic [ByteW-1:0] inq_char_q;
  logic             inq_eot_q;
  logic [BCntW-1:0] rem_q;
  logic             in_fire;
  logic             out_fire;
  logic             buf_free;
  logic             take;

  assign out_valid_o = (rem_q != '0);
  assign out_fire    = out_valid_o && !out_stall_i;
  assign buf_free    = (rem_q == '0) || (rem_q == BCntW'(1) && out_fire);
  assign take        = inq_valid_q && buf_free;
  assign in_stall_o  = inq_valid_q && !take;
  assign in_fire     = in_valid_i && !in_stall_o;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inq_valid_q <= 1'b0;
    end else if (in_fire) begin
      inq_valid_q <= 1'b1;
    end else if (take) begin
      inq_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      inq_char_q <= char_in_i;
      inq_eot_q  <= end_of_text_i;
    end
  end

  // Window state and one-item evaluation
  logic [ByteW-1:0] win_q [MAX_PATTERN];
  logic [PCntW-1:0] wcnt_q;
  logic [ByteW-1:0] win_d [MAX_PATTERN];
  logic [PCntW-1:0] wcnt_d;
  logic [ByteW-1:0] burst [BufDepth];
  logic [BCntW-1:0] burst_len;
  burst_info_t      burst_info;

  ssr_step #(
    .MAX_PATTERN    (MAX_PATTERN),
    .MAX_REPLACEMENT(MAX_REPLACEMENT)
  ) u_step (
    .win_i       (win_q),
    .wcnt_i      (wcnt_q),
    .char_i      (inq_char_q),
    .eot_i       (inq_eot_q),
    .pattern_i   (pat_bytes_q),
    .plen_i      (plen_eff),
    .repl_i      (repl_bytes_q),
    .rlen_i      (rlen_eff),
    .win_o       (win_d),
    .wcnt_o      (wcnt_d),
    .burst_o     (burst),
    .burst_len_o (burst_len),
    .burst_info_o(burst_info)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wcnt_q <= '0;
    end else if (take) begin
      wcnt_q <= wcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      win_q <= win_d;
    end
  end

  // Output buffer: loaded on take, shifted by one on each output transfer
  logic [ByteW-1:0] buf_q [BufDepth];
  burst_info_t      info_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      info_q <= '0;
    end else if (take) begin
      rem_q  <= burst_len;
      info_q <= burst_info;
    end else if (out_fire) begin
      rem_q  <= rem_q - BCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      buf_q <= burst;
    end else if (out_fire) begin
      for (int i = 0; i < BufDepth - 1; i++) begin
        buf_q[i] <= buf_q[i + 1];
      end
      buf_q[BufDepth-1] <= '0;
    end
  end

  assign char_out_o   = buf_q[0];
  assign char_valid_o = !info_q.marker;
  assign last_o       = info_q.eot && (rem_q == BCntW'(1));

  // Checks
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q <= BCntW'(BufDepth))
    else $error("output buffer count exceeds its depth");

  a_win_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wcnt_q < PCntW'(MAX_PATTERN))
    else $error("window holds a full pattern after a step");

  a_marker_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !char_valid_o |-> last_o)
    else $error("empty marker without last");

  a_last_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && last_o && !take |=> !out_valid_o)
    else $error("output still valid after final transfer");

endmodule
